/* rtl/cde_pkg.sv */
// ----------------------------------------------------------------------------
// cde_pkg
// Shared types and codes for the circular deque engine.
// ----------------------------------------------------------------------------
package cde_pkg;

    // Operation codes carried in the low bits of the input tdata.
    localparam logic [2:0] CMD_NONE      = 3'd0;
    localparam logic [2:0] CMD_INS_FRONT = 3'd1;
    localparam logic [2:0] CMD_INS_REAR  = 3'd2;
    localparam logic [2:0] CMD_DEL_FRONT = 3'd3;
    localparam logic [2:0] CMD_DEL_REAR  = 3'd4;

    // Result status codes.
    localparam logic [1:0] ST_DONE       = 2'd0;
    localparam logic [1:0] ST_FULL       = 2'd1;
    localparam logic [1:0] ST_EMPTY      = 2'd2;

    localparam int CMD_W   = 3;
    localparam int WORD_W  = 32;
    localparam int STAT_W  = 2;
    localparam int OCC_W   = 4;
    localparam int IN_W    = 40;
    localparam int OUT_W   = 72;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_LOAD
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic rd_en;
        logic load;
    } t_cde_cmd;

endpackage

/* rtl/cde_ctrl.sv */
// ----------------------------------------------------------------------------
// cde_ctrl
// Sequencer: takes one request, waits for the ring read, loads the result.
// ----------------------------------------------------------------------------
module cde_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output cde_pkg::t_cde_cmd o_cmd
);
    import cde_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   load_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // The output register may be refilled in the cycle its result is taken.
    assign load_ok = !r_out_valid || i_out_ready;

    always_comb begin
        n_state      = r_state;
        o_in_ready   = 1'b0;
        o_cmd.accept = 1'b0;
        o_cmd.rd_en  = 1'b0;
        o_cmd.load   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_LOAD;
            end
            S_LOAD: begin
                if (load_ok) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.load) begin
            n_out_valid = 1'b1;
        end else begin
            n_out_valid = r_out_valid && !i_out_ready;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

/* rtl/cde_dpath.sv */
// ----------------------------------------------------------------------------
// cde_dpath
// Ring store, head/tail indexes, word count and the result register.
// ----------------------------------------------------------------------------
module cde_dpath #(
    parameter int DEPTH = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  cde_pkg::t_cde_cmd      i_cmd,
    input  logic [cde_pkg::IN_W-1:0]  i_in_data,
    output logic [cde_pkg::OUT_W-1:0] o_out_data
);
    import cde_pkg::*;

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [WORD_W-1:0] r_ring [DEPTH];

    logic [IW-1:0]     r_head;
    logic [IW-1:0]     r_tail;
    logic [CW-1:0]     r_count;
    logic [IW-1:0]     n_head;
    logic [IW-1:0]     n_tail;
    logic [CW-1:0]     n_count;
    logic [STAT_W-1:0] r_status;
    logic [STAT_W-1:0] n_status;

    logic              wr_en;
    logic [IW-1:0]     wr_addr;
    logic [CMD_W-1:0]  in_cmd;
    logic [WORD_W-1:0] in_value;
    logic              is_full;
    logic              is_empty;
    logic [IW-1:0]     head_back;
    logic [IW-1:0]     head_fwd;
    logic [IW-1:0]     tail_back;
    logic [IW-1:0]     tail_fwd;

    logic [WORD_W-1:0] r_rd_front;
    logic [WORD_W-1:0] r_rd_rear;

    logic [STAT_W-1:0] r_out_status;
    logic [WORD_W-1:0] r_out_front;
    logic [WORD_W-1:0] r_out_rear;
    logic              r_out_empty;
    logic              r_out_full;
    logic [OCC_W-1:0]  r_out_occ;

    assign in_cmd   = i_in_data[CMD_W-1:0];
    assign in_value = i_in_data[CMD_W+WORD_W-1:CMD_W];

    assign is_full  = (r_count == FULL_CNT);
    assign is_empty = (r_count == '0);

    assign head_back = (r_head == '0)       ? LAST_IDX : r_head - 1'b1;
    assign head_fwd  = (r_head == LAST_IDX) ? '0       : r_head + 1'b1;
    assign tail_back = (r_tail == '0)       ? LAST_IDX : r_tail - 1'b1;
    assign tail_fwd  = (r_tail == LAST_IDX) ? '0       : r_tail + 1'b1;

    always_comb begin
        n_head   = r_head;
        n_tail   = r_tail;
        n_count  = r_count;
        n_status = ST_DONE;
        wr_en    = 1'b0;
        wr_addr  = '0;
        unique case (in_cmd)
            CMD_INS_FRONT, CMD_INS_REAR: begin
                priority if (is_full) begin
                    n_status = ST_FULL;
                end else if (is_empty) begin
                    // The first word always lands at index zero.
                    n_head  = '0;
                    n_tail  = '0;
                    n_count = CW'(1);
                    wr_en   = 1'b1;
                    wr_addr = '0;
                end else if (in_cmd == CMD_INS_FRONT) begin
                    n_head  = head_back;
                    n_count = r_count + 1'b1;
                    wr_en   = 1'b1;
                    wr_addr = head_back;
                end else begin
                    n_tail  = tail_fwd;
                    n_count = r_count + 1'b1;
                    wr_en   = 1'b1;
                    wr_addr = tail_fwd;
                end
            end
            CMD_DEL_FRONT, CMD_DEL_REAR: begin
                priority if (is_empty) begin
                    n_status = ST_EMPTY;
                end else if (r_count == CW'(1)) begin
                    n_head  = '0;
                    n_tail  = '0;
                    n_count = '0;
                end else if (in_cmd == CMD_DEL_FRONT) begin
                    n_head  = head_fwd;
                    n_count = r_count - 1'b1;
                end else begin
                    n_tail  = tail_back;
                    n_count = r_count - 1'b1;
                end
            end
            default: begin
                // No-op and unused codes leave the state alone.
                n_status = ST_DONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else if (i_cmd.accept) begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_status <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && wr_en) begin
            r_ring[wr_addr] <= in_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_front <= r_ring[r_head];
            r_rd_rear  <= r_ring[r_tail];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_status <= r_status;
            r_out_front  <= is_empty ? '1 : r_rd_front;
            r_out_rear   <= is_empty ? '1 : r_rd_rear;
            r_out_empty  <= is_empty;
            r_out_full   <= is_full;
            r_out_occ    <= OCC_W'(r_count);
        end
    end

    assign o_out_data = {r_out_occ, r_out_full, r_out_empty,
                         r_out_rear, r_out_front, r_out_status};

endmodule

/* rtl/circular_deque_engine.sv */
// ----------------------------------------------------------------------------
// circular_deque_engine
// Double-ended queue of 32-bit words held in a ring of DEPTH entries.
// ----------------------------------------------------------------------------
// Each request on the slave stream is one operation: none, insert front,
// insert rear, delete front or delete rear. An insert into a full deque or a
// delete from an empty one changes nothing and is flagged in the status.
// Every request yields exactly one result on the master stream carrying the
// status, the front and rear words (all ones when empty), the empty and full
// flags and the word count (low four bits).
// The indexes and the ring are updated at the accepting edge; the registered
// two-port ring read loads, then the result register, which raises tvalid.
// One request is in flight at a time, so a new request is taken only after
// the result of the last one has been loaded into the output register.
// A finished result waits in the output register while the next request is
// processed; if the receiver stalls, the engine holds the next result in
// its ring read register until the output register frees up.
// Synchronous reset empties the deque and drops any pending result; the ring
// contents are not cleared, and an unwritten entry never reaches the result.
// ----------------------------------------------------------------------------
module circular_deque_engine #(
    parameter int DEPTH = 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // cmd[2:0], value[34:3], zero pad[39:35]
    input  logic [cde_pkg::IN_W-1:0]  s_axis_tdata,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // status[1:0], front_value[33:2], rear_value[65:34], is_empty[66],
    // is_full[67], occupancy[71:68]
    output logic [cde_pkg::OUT_W-1:0] m_axis_tdata
);
    import cde_pkg::*;

    t_cde_cmd ctl_cmd;

    cde_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (ctl_cmd)
    );

    cde_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (ctl_cmd),
        .i_in_data  (s_axis_tdata),
        .o_out_data (m_axis_tdata)
    );

`ifndef SYNTHESIS
    // Only one request is worked on at a time.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request accepted while another is in flight");

    // A result can never claim both empty and full.
    a_empty_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[66] && m_axis_tdata[67]))
        else $error("result is both empty and full");

    // An empty deque reports all-ones front and rear words.
    a_empty_words: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[66]) |->
            (m_axis_tdata[33:2] == '1 && m_axis_tdata[65:34] == '1))
        else $error("empty result with data words");

    // A rejected insert means the deque was and still is full.
    a_full_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[1:0] == ST_FULL) |-> m_axis_tdata[67])
        else $error("insert rejected while not full");
`endif

endmodule
